@@ hw/rtl/sfpsc_pkg.sv @@
// ============================================================================
// sfpsc_pkg - shared types and codes for the serial frame parser
// Phase codes, result kind codes and the result word type.
// ============================================================================
`default_nettype none

package sfpsc_pkg;

  // Parser phases.
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SLAVE   = 3'd1;
  localparam logic [2:0] PH_COMMAND = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHK_HI  = 3'd5;
  localparam logic [2:0] PH_CHK_LO  = 3'd6;
  localparam logic [2:0] PH_FINAL   = 3'd7;

  // Result word kinds.
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_SUM_GOOD = 2'd1;
  localparam logic [1:0] KIND_SUM_BAD  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_START_MARKER = 1'b0;
  localparam logic CFG_END_MARKER   = 1'b1;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] frame_slave;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/sfpsc_parse.sv @@
// ============================================================================
// sfpsc_parse - frame phase tracking and checksum verdict
// Walks the frame one byte per accepted word and forms the result word.
// ============================================================================
`default_nettype none

module sfpsc_parse
  import sfpsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_fire,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] start_marker,
  input  wire logic [7:0] end_marker,
  output logic            res_valid,
  output result_t         res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  slave_r, slave_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] check_r, check_nxt;
  logic [7:0]  seen_inc;
  logic [15:0] total;

  assign seen_inc = seen_r + 8'd1;

  // Sum of the whole frame as the verdict sees it, using the current markers.
  assign total = sum_r + {8'd0, start_marker} + {8'd0, slave_r} + {8'd0, command_r}
               + {8'd0, length_r} + {8'd0, end_marker};

  always_comb begin
    phase_nxt   = phase_r;
    slave_nxt   = slave_r;
    command_nxt = command_r;
    length_nxt  = length_r;
    seen_nxt    = seen_r;
    sum_nxt     = sum_r;
    check_nxt   = check_r;
    res_valid   = 1'b0;
    res.item_kind     = KIND_PAYLOAD;
    res.frame_slave   = slave_r;
    res.frame_command = command_r;
    res.frame_length  = length_r;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == start_marker) begin
          phase_nxt = PH_SLAVE;
        end
      end
      PH_SLAVE: begin
        slave_nxt = rx_byte;
        phase_nxt = PH_COMMAND;
      end
      PH_COMMAND: begin
        command_nxt = rx_byte;
        phase_nxt   = PH_LENGTH;
      end
      PH_LENGTH: begin
        length_nxt = rx_byte;
        seen_nxt   = 8'd0;
        sum_nxt    = 16'd0;
        phase_nxt  = (rx_byte == 8'd0) ? PH_CHK_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = seen_r;
        sum_nxt           = sum_r + {8'd0, rx_byte};
        seen_nxt          = seen_inc;
        if (seen_inc >= length_r) begin
          phase_nxt = PH_CHK_HI;
        end
      end
      PH_CHK_HI: begin
        check_nxt = {rx_byte, 8'd0};
        phase_nxt = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        check_nxt = {check_r[15:8], rx_byte};
        phase_nxt = PH_FINAL;
      end
      default: begin
        // Final byte: its value is not looked at.
        res_valid     = 1'b1;
        res.item_kind = (total == check_r) ? KIND_SUM_GOOD : KIND_SUM_BAD;
        phase_nxt     = PH_HUNT;
      end
    endcase
    if (!byte_fire) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      slave_r   <= 8'd0;
      command_r <= 8'd0;
      length_r  <= 8'd0;
      seen_r    <= 8'd0;
      sum_r     <= 16'd0;
      check_r   <= 16'd0;
    end else if (byte_fire) begin
      phase_r   <= phase_nxt;
      slave_r   <= slave_nxt;
      command_r <= command_nxt;
      length_r  <= length_nxt;
      seen_r    <= seen_nxt;
      sum_r     <= sum_nxt;
      check_r   <= check_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/serial_frame_parser_sum_check.sv @@
// ============================================================================
// serial_frame_parser_sum_check - serial frame parser with additive checksum
// Hunts for the start byte, passes payload bytes on and gives a verdict word.
// ============================================================================
// Result path: a result word is formed from the accepted byte and registered
//   in the output register, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while the skid entry is empty; a two-entry
//   output stage keeps input flowing while a result waits.
// Reset: synchronous, active low; clears the parser to hunting, both markers
//   to zero and empties the output stage.
`default_nettype none

module serial_frame_parser_sum_check
  import sfpsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Received byte words.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // Result words.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_item_kind,
  output logic [7:0]      out_frame_slave,
  output logic [7:0]      out_frame_command,
  output logic [7:0]      out_frame_length,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_payload_index,
  // Configuration writes.
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic [7:0] start_marker_r;
  logic [7:0] end_marker_r;

  logic    in_fire;
  logic    res_valid;
  result_t res;

  // Output stage: the visible output register plus one skid entry.
  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  logic    out_free;

  // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= 8'd0;
      end_marker_r   <= 8'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START_MARKER: start_marker_r <= cfg_wdata;
        CFG_END_MARKER:   end_marker_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input is taken whenever the skid entry is empty, so a result held in the
  // output register does not hold up the byte stream.
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;

  sfpsc_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_fire    (in_fire),
    .rx_byte      (in_rx_byte),
    .start_marker (start_marker_r),
    .end_marker   (end_marker_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  assign out_free = !out_valid_r || !out_stall;

  // When the output register drains, it refills from the skid entry first;
  // while the skid entry is full no new byte is accepted, so no result can
  // arrive in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || res_valid;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (!out_free && res_valid) begin
      skid_data_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_kind     = out_data_r.item_kind;
  assign out_frame_slave   = out_data_r.frame_slave;
  assign out_frame_command = out_data_r.frame_command;
  assign out_frame_length  = out_data_r.frame_length;
  assign out_payload_byte  = out_data_r.payload_byte;
  assign out_payload_index = out_data_r.payload_index;

endmodule

`default_nettype wire

@@ hw/rtl/sfpsc_checker.sv @@
// ============================================================================
// sfpsc_checker - port level checks for the serial frame parser
// Watches the top level's ports and is bound to it.
// ============================================================================
`default_nettype none

module sfpsc_checker
  import sfpsc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_item_kind,
  input wire logic [7:0] out_frame_length,
  input wire logic [7:0] out_payload_byte,
  input wire logic [7:0] out_payload_index
);

  // A result word does not vanish while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // The output stage is empty in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // Only the three defined kinds leave the block.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item_kind == KIND_PAYLOAD) || (out_item_kind == KIND_SUM_GOOD)
                  || (out_item_kind == KIND_SUM_BAD))
    else $error("undefined result kind");

  // Payload words stay inside the declared length; verdicts carry zeros.
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_PAYLOAD |-> out_payload_index < out_frame_length)
    else $error("payload index beyond frame length");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind != KIND_PAYLOAD
      |-> out_payload_byte == 8'd0 && out_payload_index == 8'd0)
    else $error("verdict word carries payload data");

endmodule

bind serial_frame_parser_sum_check sfpsc_checker u_sfpsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_item_kind     (out_item_kind),
  .out_frame_length  (out_frame_length),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index)
);

`default_nettype wire

@@ tb/frame_word_checker.sv @@
// ============================================================================
// frame_word_checker - result checker for the serial frame parser
// Watches the byte, result and register ports, tracks the frame parser state
// and compares every result word with the oldest outstanding prediction.
// ============================================================================
`timescale 1ns / 100ps

module frame_word_checker
  import sfpsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [1:0] out_item_kind,
  input  wire logic [7:0] out_frame_slave,
  input  wire logic [7:0] out_frame_command,
  input  wire logic [7:0] out_frame_length,
  input  wire logic [7:0] out_payload_byte,
  input  wire logic [7:0] out_payload_index,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output int              fail_count,
  output int              pending,
  output int              n_payload,
  output int              n_good,
  output int              n_bad
);

  result_t     expected_words[$];

  // Shadow copy of the markers and of the parser state.
  logic [7:0]  start_mk;
  logic [7:0]  end_mk;
  logic [2:0]  phase;
  logic [7:0]  slave_q;
  logic [7:0]  command_q;
  logic [7:0]  length_q;
  logic [7:0]  seen_q;
  logic [15:0] sum_q;
  logic [15:0] check_q;

  task automatic advance_parser(input logic [7:0] b);
    result_t     w;
    logic [15:0] total;
    w = '0;
    case (phase)
      PH_HUNT: begin
        if (b == start_mk) phase = PH_SLAVE;
      end
      PH_SLAVE: begin
        slave_q = b;
        phase   = PH_COMMAND;
      end
      PH_COMMAND: begin
        command_q = b;
        phase     = PH_LENGTH;
      end
      PH_LENGTH: begin
        length_q = b;
        seen_q   = 8'd0;
        sum_q    = 16'd0;
        phase    = (b == 8'd0) ? PH_CHK_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        w.item_kind     = KIND_PAYLOAD;
        w.frame_slave   = slave_q;
        w.frame_command = command_q;
        w.frame_length  = length_q;
        w.payload_byte  = b;
        w.payload_index = seen_q;
        expected_words.insert(expected_words.size(), w);
        sum_q  = sum_q + {8'd0, b};
        seen_q = seen_q + 8'd1;
        if (seen_q >= length_q) phase = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        check_q = {b, 8'h00};
        phase   = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        check_q[7:0] = b;
        phase        = PH_FINAL;
      end
      default: begin
        // The final byte is taken whatever its value; the markers in force now
        // enter the sum.
        total = sum_q + {8'd0, start_mk} + {8'd0, slave_q} + {8'd0, command_q}
              + {8'd0, length_q} + {8'd0, end_mk};
        w.item_kind     = (total == check_q) ? KIND_SUM_GOOD : KIND_SUM_BAD;
        w.frame_slave   = slave_q;
        w.frame_command = command_q;
        w.frame_length  = length_q;
        expected_words.insert(expected_words.size(), w);
        phase = PH_HUNT;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      start_mk  = 8'd0;
      end_mk    = 8'd0;
      phase     = PH_HUNT;
      slave_q   = 8'd0;
      command_q = 8'd0;
      length_q  = 8'd0;
      seen_q    = 8'd0;
      sum_q     = 16'd0;
      check_q   = 16'd0;
      expected_words.delete();
    end else begin
      // Results first, so that a word cannot match a prediction made this edge.
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none expected: kind %0h slave %0h command %0h",
                   $time, out_item_kind, out_frame_slave, out_frame_command);
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          compare_field("item_kind", {6'd0, want.item_kind}, {6'd0, out_item_kind});
          compare_field("frame_slave", want.frame_slave, out_frame_slave);
          compare_field("frame_command", want.frame_command, out_frame_command);
          compare_field("frame_length", want.frame_length, out_frame_length);
          compare_field("payload_byte", want.payload_byte, out_payload_byte);
          compare_field("payload_index", want.payload_index, out_payload_index);
          case (want.item_kind)
            KIND_PAYLOAD:  n_payload++;
            KIND_SUM_GOOD: n_good++;
            default:       n_bad++;
          endcase
        end
      end
      // A byte taken at this edge still sees the markers from before a write
      // at the same edge.
      if (in_valid && !in_stall) advance_parser(in_rx_byte);
      if (cfg_wr_en) begin
        if (cfg_index == CFG_START_MARKER) start_mk = cfg_wdata;
        else end_mk = cfg_wdata;
      end
    end
    pending = expected_words.size();
  end

endmodule

@@ tb/tb.sv @@
// ============================================================================
// tb - testbench top for serial_frame_parser_sum_check
// Drives byte words and marker writes into the parser, stalls the result side
// at random and leaves all checking to frame_word_checker and the bound sfpsc_checker.
// ============================================================================
`timescale 1ns / 100ps

module tb;
  import sfpsc_pkg::*;

  typedef enum int { PAT_RANDOM, PAT_ONES, PAT_ZEROS, PAT_START } pattern_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_item_kind;
  logic [7:0] out_frame_slave;
  logic [7:0] out_frame_command;
  logic [7:0] out_frame_length;
  logic [7:0] out_payload_byte;
  logic [7:0] out_payload_index;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  int fail_count;
  int pending;
  int n_payload;
  int n_good;
  int n_bad;

  // Pacing knobs, in percent of cycles, and the request for a long hold-off.
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  // The markers as last written, used to build well-formed frames.
  logic [7:0] start_mk;
  logic [7:0] end_mk;
  int         bytes_sent;
  int         long_frames;

  serial_frame_parser_sum_check dut (.*);

  frame_word_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side. Normally it stalls at random at the current rate; on request
  // it holds off for a long stretch so that the output stage fills up and the
  // parser has to stall its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offers one byte word and returns at the edge where it is taken. Valid is
  // left high so that back-to-back words need no second assignment in a step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops offering bytes and waits until every predicted result has come out,
  // then lets the parser finish any word that makes no result. Pending is
  // looked at on the falling edge, clear of the checker.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes both markers; the parser must be idle when this is called.
  task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_START_MARKER;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= CFG_END_MARKER;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    start_mk = s;
    end_mk   = e;
    @(posedge clk);
  endtask

  // Sends a whole frame. The checksum is built from the markers in force when
  // the checksum bytes go out, then optionally spoilt by an XOR mask. With
  // remark set, the markers are changed just after the header, mid-frame.
  task automatic send_frame(input logic [7:0] slave, input logic [7:0] command,
                            input logic [7:0] length, input pattern_t pat,
                            input logic [15:0] flip, input bit remark);
    logic [7:0]  b;
    logic [15:0] total;
    send_byte(start_mk);
    send_byte(slave);
    send_byte(command);
    send_byte(length);
    if (remark) begin
      settle();
      set_markers(8'($urandom), 8'($urandom));
    end
    total = 16'(slave) + 16'(command) + 16'(length);
    for (int i = 0; i < length; i++) begin
      case (pat)
        PAT_ONES:  b = 8'hFF;
        PAT_ZEROS: b = 8'h00;
        PAT_START: b = start_mk;
        default:   b = 8'($urandom);
      endcase
      total += 16'(b);
      send_byte(b);
    end
    total += 16'(start_mk) + 16'(end_mk);
    total ^= flip;
    send_byte(total[15:8]);
    send_byte(total[7:0]);
    // The closing byte is never looked at, so any value will do.
    send_byte(8'($urandom));
  endtask

  // One chunk of random traffic: mostly well-formed frames with random
  // content, now and then a burst of raw line noise that may open a frame
  // anywhere and knock the parser out of step for a while.
  task automatic send_random_traffic();
    logic [7:0]  b;
    logic [7:0]  len;
    logic [15:0] flip;
    pattern_t    pat;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 12) begin
      repeat ($urandom_range(12, 1)) send_byte(8'($urandom));
    end else begin
      // A little harmless noise ahead of the frame while hunting.
      repeat ($urandom_range(2)) begin
        do b = 8'($urandom); while (b == start_mk);
        send_byte(b);
      end
      roll = $urandom_range(99);
      if (roll < 3 && long_frames < 4) begin
        len = 8'd255;
        long_frames++;
      end else if (roll < 70) begin
        len = 8'($urandom_range(8));
      end else begin
        len = 8'($urandom_range(40, 9));
      end
      case ($urandom_range(9))
        7:       pat = PAT_ONES;
        8:       pat = PAT_ZEROS;
        9:       pat = PAT_START;
        default: pat = PAT_RANDOM;
      endcase
      if ($urandom_range(99) < 25) flip = 16'($urandom_range(65535, 1));
      else flip = 16'h0000;
      send_frame(8'($urandom), 8'($urandom), len, pat, flip, $urandom_range(99) < 3);
    end
  endtask

  initial begin
    int target;
    in_valid       = 1'b0;
    in_rx_byte     = 8'h00;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_START_MARKER;
    cfg_wdata      = 8'h00;
    rst_n          = 1'b0;
    start_mk       = 8'h00;
    end_mk         = 8'h00;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    bytes_sent     = 0;
    long_frames    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with both markers still at their reset value of zero.
    // Two stray bytes while hunting must be dropped.
    send_byte(8'hA5);
    send_byte(8'hFF);
    // Zero-length frame, all-zero header, checksum received as all ones.
    send_frame(8'h00, 8'h00, 8'd0, PAT_RANDOM, 16'hFFFF, 1'b0);
    // Zero-length frame with all-ones slave and command bytes and a good checksum.
    send_frame(8'hFF, 8'hFF, 8'd0, PAT_RANDOM, 16'h0000, 1'b0);
    // Payload made of the start value, which must count as plain data.
    send_frame(8'h5A, 8'h81, 8'd2, PAT_START, 16'h0000, 1'b0);

    // Random part in four pacing phases, the markers changed between them.
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_markers(8'hFF, 8'hFF);
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
          set_markers(8'h7E, 8'h0D);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
          set_markers(8'($urandom), 8'($urandom));
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct = 7;
          set_markers(8'h00, 8'hFF);
        end
      endcase
      if (ph == 0) begin
        // Hold the result side off while a long frame streams in, so that the
        // output stage fills and back-pressure reaches the byte input.
        hold_req = 1'b1;
        send_frame(8'($urandom), 8'($urandom), 8'd60, PAT_RANDOM, 16'h0000, 1'b0);
        // Largest frame, all-ones payload: the sum wraps past 16 bits and the
        // payload index runs up to 254.
        send_frame(8'hFF, 8'hFF, 8'd255, PAT_ONES, 16'h0000, 1'b0);
        long_frames++;
      end
      target = bytes_sent + 310;
      while (bytes_sent < target) send_random_traffic();
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Sent %0d byte words over four pacing phases and five marker settings;",
             bytes_sent);
    $display("checked %0d payload words, %0d good and %0d bad checksum verdicts.",
             n_payload, n_good, n_bad);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d result words still outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
